### rtl/core/v3u_pkg.sv
// Shared types, constants and arithmetic helpers for the vector operation unit.
`default_nettype none
package v3u_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ANG_W        = 34;
    localparam int ROT_FRAC     = 30;
    localparam int ISQRT_STEPS  = 32;
    localparam int DIV_STEPS    = FRAC_BITS + 1;
    localparam int NUM_W        = 33 + FRAC_BITS;
    localparam int SHIFT_W      = 5;

    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam int CLAMP_LAT = 1;
    localparam int CROSS_LAT = 2;
    localparam int ROT_LAT   = CORDIC_STEPS + 4;
    localparam int NORM_LAT  = ISQRT_STEPS + DIV_STEPS + 6;
    localparam int PIPE_LAT  = NORM_LAT;

    typedef logic signed [31:0] t_fix;

    typedef enum logic [2:0] {
        KIND_CLAMP = 3'd0,
        KIND_CROSS = 3'd1,
        KIND_ROT_X = 3'd2,
        KIND_ROT_Y = 3'd3,
        KIND_ROT_Z = 3'd4,
        KIND_NORM  = 3'd5
    } t_kind;

    typedef struct packed {
        t_fix rx;
        t_fix ry;
        t_fix rz;
        logic saturated;
        logic zero_length;
    } t_res;

    function automatic logic signed [ANG_W-1:0] atan_turn(input int idx);
        case (idx)
            0:       atan_turn = 34'sh020000000;
            1:       atan_turn = 34'sh012E4051E;
            2:       atan_turn = 34'sh009FB385B;
            3:       atan_turn = 34'sh0051111D4;
            4:       atan_turn = 34'sh0028B0D43;
            5:       atan_turn = 34'sh00145D7E1;
            6:       atan_turn = 34'sh000A2F61E;
            7:       atan_turn = 34'sh000517C55;
            8:       atan_turn = 34'sh00028BE53;
            9:       atan_turn = 34'sh000145F2F;
            10:      atan_turn = 34'sh0000A2F98;
            11:      atan_turn = 34'sh0000517CC;
            12:      atan_turn = 34'sh000028BE6;
            13:      atan_turn = 34'sh0000145F3;
            14:      atan_turn = 34'sh000000A2FA;
            15:      atan_turn = 34'sh00000517D;
            16:      atan_turn = 34'sh0000028BE;
            17:      atan_turn = 34'sh00000145F;
            18:      atan_turn = 34'sh000000A30;
            19:      atan_turn = 34'sh000000518;
            20:      atan_turn = 34'sh00000028C;
            21:      atan_turn = 34'sh000000146;
            22:      atan_turn = 34'sh0000000A3;
            23:      atan_turn = 34'sh000000051;
            default: atan_turn = '0;
        endcase
    endfunction

    // Rounds half up by sh bits, then saturates to 32 bits; the top bit is the flag.
    function automatic logic [32:0] round_sat(input logic signed [64:0] d, input int sh);
        logic signed [65:0] v;
        v = 66'(d >>> sh) + 66'(d[sh-1]);
        if (v > 66'sd2147483647) begin
            round_sat = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -66'sd2147483648) begin
            round_sat = {1'b1, 32'h8000_0000};
        end else begin
            round_sat = {1'b0, v[31:0]};
        end
    endfunction

endpackage
`default_nettype wire

### rtl/core/vector3_op_unit.sv
// Top level of the three-component vector operation unit.
//
// Each input transaction carries an operation code, vectors A and B, an angle
// and clamp bounds; each one produces exactly one output transaction with the
// result vector and the saturated and zero-length flags.
// Both channels use valid and ready. The unit is a fixed-depth pipeline that
// accepts one transaction per cycle unless stalled and returns results in
// input order. The normalize path sets the depth: squares, scaling, a
// 32-stage square root and a 17-stage divider. Shorter paths are delayed
// to the same depth.
// Throughput is one transaction per cycle while the receiver takes results.
// When the receiver holds ready low with a result waiting, the whole pipeline
// freezes and input ready drops; nothing is lost or repeated.
// Reset clears all valid bits, so no result appears until new input arrives.
`default_nettype none
module vector3_op_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [2:0]    i_kind,
    input  v3u_pkg::t_fix i_ax,
    input  v3u_pkg::t_fix i_ay,
    input  v3u_pkg::t_fix i_az,
    input  v3u_pkg::t_fix i_bx,
    input  v3u_pkg::t_fix i_by,
    input  v3u_pkg::t_fix i_bz,
    input  logic [15:0]   i_angle,
    input  v3u_pkg::t_fix i_clip_low,
    input  v3u_pkg::t_fix i_clip_high,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output v3u_pkg::t_fix o_rx,
    output v3u_pkg::t_fix o_ry,
    output v3u_pkg::t_fix o_rz,
    output logic          o_saturated,
    output logic          o_zero_length
);
    import v3u_pkg::*;

    localparam int CLAMP_D = PIPE_LAT - CLAMP_LAT;
    localparam int CROSS_D = PIPE_LAT - CROSS_LAT;
    localparam int ROT_D   = PIPE_LAT - ROT_LAT;

    logic               w_en;
    logic [PIPE_LAT:0]  r_vld;
    logic [2:0]         r_kind_d [PIPE_LAT];
    t_fix               w_a [3];
    t_fix               w_clamp [3];
    t_res               r_clamp;
    t_res               r_clamp_d [CLAMP_D];
    logic signed [63:0] r_cp1 [3];
    logic signed [63:0] r_cp2 [3];
    logic [32:0]        w_cr [3];
    t_res               r_cross;
    t_res               r_cross_d [CROSS_D];
    t_res               w_rot;
    t_res               r_rot_d [ROT_D];
    t_res               w_norm;
    t_res               n_out;
    t_res               r_out;

    assign w_en       = !r_vld[PIPE_LAT] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-1:0], i_in_valid};
        end
    end

    assign w_a[0] = i_ax;
    assign w_a[1] = i_ay;
    assign w_a[2] = i_az;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_clamp[j] = w_a[j];
            if (w_clamp[j] < i_clip_low) begin
                w_clamp[j] = i_clip_low;
            end
            if (w_clamp[j] > i_clip_high) begin
                w_clamp[j] = i_clip_high;
            end
            if (i_kind != KIND_CLAMP) begin
                w_clamp[j] = w_a[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kind_d[0] <= i_kind;
            for (int i = 1; i < PIPE_LAT; i++) begin
                r_kind_d[i] <= r_kind_d[i-1];
            end
            r_clamp <= '{rx: w_clamp[0], ry: w_clamp[1], rz: w_clamp[2],
                         saturated: 1'b0, zero_length: 1'b0};
            r_cp1[0] <= i_ay * i_bz;
            r_cp2[0] <= i_az * i_by;
            r_cp1[1] <= i_az * i_bx;
            r_cp2[1] <= i_ax * i_bz;
            r_cp1[2] <= i_ax * i_by;
            r_cp2[2] <= i_ay * i_bx;
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_cr[j] = round_sat(65'(r_cp1[j]) - 65'(r_cp2[j]), FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cross <= '{rx: w_cr[0][31:0], ry: w_cr[1][31:0], rz: w_cr[2][31:0],
                         saturated: w_cr[0][32] | w_cr[1][32] | w_cr[2][32],
                         zero_length: 1'b0};
            r_clamp_d[0] <= r_clamp;
            for (int i = 1; i < CLAMP_D; i++) begin
                r_clamp_d[i] <= r_clamp_d[i-1];
            end
            r_cross_d[0] <= r_cross;
            for (int i = 1; i < CROSS_D; i++) begin
                r_cross_d[i] <= r_cross_d[i-1];
            end
            r_rot_d[0] <= w_rot;
            for (int i = 1; i < ROT_D; i++) begin
                r_rot_d[i] <= r_rot_d[i-1];
            end
        end
    end

    v3u_rot u_rot (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_kind  (i_kind),
        .i_ax    (i_ax),
        .i_ay    (i_ay),
        .i_az    (i_az),
        .i_angle (i_angle),
        .o_res   (w_rot)
    );

    v3u_norm u_norm (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ax  (i_ax),
        .i_ay  (i_ay),
        .i_az  (i_az),
        .o_res (w_norm)
    );

    always_comb begin
        case (r_kind_d[PIPE_LAT-1])
            KIND_CROSS: n_out = r_cross_d[CROSS_D-1];
            KIND_ROT_X: n_out = r_rot_d[ROT_D-1];
            KIND_ROT_Y: n_out = r_rot_d[ROT_D-1];
            KIND_ROT_Z: n_out = r_rot_d[ROT_D-1];
            KIND_NORM:  n_out = w_norm;
            default:    n_out = r_clamp_d[CLAMP_D-1];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_vld[PIPE_LAT];
    assign o_rx          = r_out.rx;
    assign o_ry          = r_out.ry;
    assign o_rz          = r_out.rz;
    assign o_saturated   = r_out.saturated;
    assign o_zero_length = r_out.zero_length;

endmodule
`default_nettype wire

### rtl/core/v3u_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module v3u_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_n,
    output logic [31:0] o_q
);
    import v3u_pkg::*;

    logic [63:0] r_n   [ISQRT_STEPS];
    logic [63:0] r_res [ISQRT_STEPS];

    for (genvar gi = 0; gi < ISQRT_STEPS; gi++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * gi);
        logic [63:0] w_n;
        logic [63:0] w_res;
        logic [64:0] w_sum;
        logic        w_ge;

        if (gi == 0) begin : g_first
            assign w_n   = i_n;
            assign w_res = '0;
        end else begin : g_next
            assign w_n   = r_n[gi-1];
            assign w_res = r_res[gi-1];
        end

        assign w_sum = {1'b0, w_res} + {1'b0, BIT};
        assign w_ge  = {1'b0, w_n} >= w_sum;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[gi]   <= w_ge ? (w_n - w_sum[63:0]) : w_n;
                r_res[gi] <= w_ge ? ((w_res >> 1) + BIT) : (w_res >> 1);
            end
        end
    end

    assign o_q = r_res[ISQRT_STEPS-1][31:0];

endmodule
`default_nettype wire

### rtl/core/v3u_div.sv
// Pipelined restoring divider for three numerators over one shared divisor.
`default_nettype none
module v3u_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [v3u_pkg::NUM_W-1:0]     i_num [3],
    input  logic [31:0]                   i_q,
    output logic [v3u_pkg::DIV_STEPS-1:0] o_quo [3]
);
    import v3u_pkg::*;

    logic [31:0]          r_rem [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] r_low [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] r_quo [DIV_STEPS][3];
    logic [31:0]          r_q   [DIV_STEPS];

    for (genvar gi = 0; gi < DIV_STEPS; gi++) begin : g_stage
        logic [31:0]          w_rem [3];
        logic [DIV_STEPS-1:0] w_low [3];
        logic [DIV_STEPS-1:0] w_quo [3];
        logic [31:0]          w_q;

        if (gi == 0) begin : g_first
            always_comb begin
                for (int j = 0; j < 3; j++) begin
                    w_rem[j] = i_num[j][NUM_W-1:DIV_STEPS];
                    w_low[j] = i_num[j][DIV_STEPS-1:0];
                    w_quo[j] = '0;
                end
            end
            assign w_q = i_q;
        end else begin : g_next
            always_comb begin
                for (int j = 0; j < 3; j++) begin
                    w_rem[j] = r_rem[gi-1][j];
                    w_low[j] = r_low[gi-1][j];
                    w_quo[j] = r_quo[gi-1][j];
                end
            end
            assign w_q = r_q[gi-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[gi] <= w_q;
                for (int j = 0; j < 3; j++) begin
                    if ({w_rem[j], w_low[j][DIV_STEPS-1]} >= {1'b0, w_q}) begin
                        r_rem[gi][j] <= 32'({w_rem[j], w_low[j][DIV_STEPS-1]} - {1'b0, w_q});
                        r_quo[gi][j] <= {w_quo[j][DIV_STEPS-2:0], 1'b1};
                    end else begin
                        r_rem[gi][j] <= {w_rem[j][30:0], w_low[j][DIV_STEPS-1]};
                        r_quo[gi][j] <= {w_quo[j][DIV_STEPS-2:0], 1'b0};
                    end
                    r_low[gi][j] <= w_low[j] << 1;
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule
`default_nettype wire

### rtl/core/v3u_norm.sv
// Normalize pipeline: squared length, scaling, square root and division.
`default_nettype none
module v3u_norm (
    input  logic          i_clk,
    input  logic          i_en,
    input  v3u_pkg::t_fix i_ax,
    input  v3u_pkg::t_fix i_ay,
    input  v3u_pkg::t_fix i_az,
    output v3u_pkg::t_res o_res
);
    import v3u_pkg::*;

    localparam int MAG_D = ISQRT_STEPS + 4;

    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][31:0] m;
    } t_mag;

    typedef struct packed {
        logic               zero;
        logic [SHIFT_W-1:0] k;
    } t_kz;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } t_aux;

    t_fix               w_a [3];
    t_mag               w_mag;
    logic signed [63:0] r1_sq [3];
    t_mag               r_mag [MAG_D];
    logic [63:0]        r2_s;
    logic [63:0]        n3_s;
    logic [SHIFT_W-1:0] n3_k;
    logic [63:0]        r3_s;
    logic [SHIFT_W-1:0] r3_k;
    logic               r3_zero;
    logic [63:0]        n4_s;
    logic [SHIFT_W-1:0] n4_k;
    logic [63:0]        r4_s;
    logic [SHIFT_W-1:0] r4_k;
    logic               r4_zero;
    t_kz                r_kz [ISQRT_STEPS];
    logic [31:0]        w_q;
    logic [NUM_W-1:0]   r5_num [3];
    logic [31:0]        r5_q;
    t_aux               r_aux [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] w_quo [3];
    t_res               n_res;
    t_res               r_res;

    assign w_a[0] = i_ax;
    assign w_a[1] = i_ay;
    assign w_a[2] = i_az;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_mag.neg[j] = w_a[j][31];
            w_mag.m[j]   = w_a[j][31] ? 32'(-w_a[j]) : w_a[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r1_sq[j] <= w_a[j] * w_a[j];
            end
            r_mag[0] <= w_mag;
            for (int i = 1; i < MAG_D; i++) begin
                r_mag[i] <= r_mag[i-1];
            end
            r2_s <= $unsigned(r1_sq[0]) + $unsigned(r1_sq[1]) + $unsigned(r1_sq[2]);
        end
    end

    always_comb begin
        n3_s = r2_s;
        n3_k = '0;
        if (n3_s[63:32] == 32'd0) begin
            n3_s = {n3_s[31:0], 32'd0};
            n3_k = n3_k + 5'd16;
        end
        if (n3_s[63:48] == 16'd0) begin
            n3_s = {n3_s[47:0], 16'd0};
            n3_k = n3_k + 5'd8;
        end
        if (n3_s[63:56] == 8'd0) begin
            n3_s = {n3_s[55:0], 8'd0};
            n3_k = n3_k + 5'd4;
        end
    end

    always_comb begin
        n4_s = r3_s;
        n4_k = r3_k;
        if (n4_s[63:60] == 4'd0) begin
            n4_s = {n4_s[59:0], 4'd0};
            n4_k = n4_k + 5'd2;
        end
        if (n4_s[63:62] == 2'd0) begin
            n4_s = {n4_s[61:0], 2'd0};
            n4_k = n4_k + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_s    <= n3_s;
            r3_k    <= n3_k;
            r3_zero <= (r2_s == 64'd0);
            r4_s    <= n4_s;
            r4_k    <= n4_k;
            r4_zero <= r3_zero;
            r_kz[0] <= '{zero: r4_zero, k: r4_k};
            for (int i = 1; i < ISQRT_STEPS; i++) begin
                r_kz[i] <= r_kz[i-1];
            end
        end
    end

    v3u_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_n   (r4_s),
        .o_q   (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r5_num[j] <= (NUM_W'(r_mag[MAG_D-1].m[j])
                              << (FRAC_BITS + int'(r_kz[ISQRT_STEPS-1].k)))
                             + NUM_W'(w_q >> 1);
            end
            r5_q     <= w_q;
            r_aux[0] <= '{neg: r_mag[MAG_D-1].neg, zero: r_kz[ISQRT_STEPS-1].zero};
            for (int i = 1; i <= DIV_STEPS; i++) begin
                r_aux[i] <= r_aux[i-1];
            end
        end
    end

    v3u_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r5_num),
        .i_q   (r5_q),
        .o_quo (w_quo)
    );

    always_comb begin
        n_res.saturated   = 1'b0;
        n_res.zero_length = r_aux[DIV_STEPS].zero;
        if (r_aux[DIV_STEPS].zero) begin
            n_res.rx = '0;
            n_res.ry = '0;
            n_res.rz = t_fix'(32'd1 << FRAC_BITS);
        end else begin
            n_res.rx = r_aux[DIV_STEPS].neg[0] ? -t_fix'(32'(w_quo[0])) : t_fix'(32'(w_quo[0]));
            n_res.ry = r_aux[DIV_STEPS].neg[1] ? -t_fix'(32'(w_quo[1])) : t_fix'(32'(w_quo[1]));
            n_res.rz = r_aux[DIV_STEPS].neg[2] ? -t_fix'(32'(w_quo[2])) : t_fix'(32'(w_quo[2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

### rtl/core/v3u_rot.sv
// Axis rotation pipeline: angle fold, CORDIC sine and cosine, products and rounding.
`default_nettype none
module v3u_rot (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [2:0]    i_kind,
    input  v3u_pkg::t_fix i_ax,
    input  v3u_pkg::t_fix i_ay,
    input  v3u_pkg::t_fix i_az,
    input  logic [15:0]   i_angle,
    output v3u_pkg::t_res o_res
);
    import v3u_pkg::*;

    localparam int SIDE_D = CORDIC_STEPS + 2;

    typedef struct packed {
        logic       flip;
        logic [2:0] kind;
        t_fix       p;
        t_fix       q;
        t_fix       pass;
    } t_side;

    logic [15:0]               w_sum;
    logic [15:0]               w_a;
    t_side                     w_side;
    logic signed [ANG_W-1:0]   r_f_z;
    t_side                     r_side [SIDE_D];
    logic signed [ANG_W-1:0]   r_cx [CORDIC_STEPS];
    logic signed [ANG_W-1:0]   r_cy [CORDIC_STEPS];
    logic signed [ANG_W-1:0]   r_cz [CORDIC_STEPS];
    logic signed [ANG_W-1:0]   w_s;
    logic signed [ANG_W-1:0]   w_c;
    t_fix                      r_s;
    t_fix                      r_c;
    logic signed [63:0]        r_cp;
    logic signed [63:0]        r_sq;
    logic signed [63:0]        r_sp;
    logic signed [63:0]        r_cq;
    t_fix                      r_pass;
    logic [2:0]                r_kind;
    logic [32:0]               w_o1;
    logic [32:0]               w_o2;
    t_res                      n_res;
    t_res                      r_res;

    assign w_sum = i_angle + 16'd16384;
    assign w_a   = i_angle ^ {w_sum[15], 15'd0};

    always_comb begin
        w_side.flip = w_sum[15];
        w_side.kind = i_kind;
        case (i_kind)
            KIND_ROT_X: begin
                w_side.p    = i_ay;
                w_side.q    = i_az;
                w_side.pass = i_ax;
            end
            KIND_ROT_Y: begin
                w_side.p    = i_az;
                w_side.q    = i_ax;
                w_side.pass = i_ay;
            end
            default: begin
                w_side.p    = i_ax;
                w_side.q    = i_ay;
                w_side.pass = i_az;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_z     <= ANG_W'($signed({w_a, 16'h0000}));
            r_side[0] <= w_side;
            for (int i = 1; i < SIDE_D; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
        logic signed [ANG_W-1:0] w_x;
        logic signed [ANG_W-1:0] w_y;
        logic signed [ANG_W-1:0] w_z;
        logic signed [ANG_W-1:0] w_dx;
        logic signed [ANG_W-1:0] w_dy;

        if (gi == 0) begin : g_first
            assign w_x = CORDIC_GAIN;
            assign w_y = '0;
            assign w_z = r_f_z;
        end else begin : g_next
            assign w_x = r_cx[gi-1];
            assign w_y = r_cy[gi-1];
            assign w_z = r_cz[gi-1];
        end

        assign w_dx = w_y >>> gi;
        assign w_dy = w_x >>> gi;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_z[ANG_W-1]) begin
                    r_cx[gi] <= w_x - w_dx;
                    r_cy[gi] <= w_y + w_dy;
                    r_cz[gi] <= w_z - atan_turn(gi);
                end else begin
                    r_cx[gi] <= w_x + w_dx;
                    r_cy[gi] <= w_y - w_dy;
                    r_cz[gi] <= w_z + atan_turn(gi);
                end
            end
        end
    end

    assign w_s = r_side[CORDIC_STEPS].flip ? -r_cy[CORDIC_STEPS-1] : r_cy[CORDIC_STEPS-1];
    assign w_c = r_side[CORDIC_STEPS].flip ? -r_cx[CORDIC_STEPS-1] : r_cx[CORDIC_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s    <= w_s[31:0];
            r_c    <= w_c[31:0];
            r_cp   <= r_c * r_side[SIDE_D-1].p;
            r_sq   <= r_s * r_side[SIDE_D-1].q;
            r_sp   <= r_s * r_side[SIDE_D-1].p;
            r_cq   <= r_c * r_side[SIDE_D-1].q;
            r_pass <= r_side[SIDE_D-1].pass;
            r_kind <= r_side[SIDE_D-1].kind;
        end
    end

    assign w_o1 = round_sat(65'(r_cp) - 65'(r_sq), ROT_FRAC);
    assign w_o2 = round_sat(65'(r_sp) + 65'(r_cq), ROT_FRAC);

    always_comb begin
        n_res.saturated   = w_o1[32] | w_o2[32];
        n_res.zero_length = 1'b0;
        case (r_kind)
            KIND_ROT_X: begin
                n_res.rx = r_pass;
                n_res.ry = w_o1[31:0];
                n_res.rz = w_o2[31:0];
            end
            KIND_ROT_Y: begin
                n_res.rx = w_o2[31:0];
                n_res.ry = r_pass;
                n_res.rz = w_o1[31:0];
            end
            default: begin
                n_res.rx = w_o1[31:0];
                n_res.ry = w_o2[31:0];
                n_res.rz = r_pass;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

### rtl/core/v3u_checker.sv
// Port-level checks for the vector operation unit and their binding.
`default_nettype none
module v3u_checker (
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          o_in_ready,
    input wire [31:0]   o_rx,
    input wire [31:0]   o_ry,
    input wire [31:0]   o_rz,
    input wire          o_out_valid,
    input wire          i_out_ready,
    input wire          o_saturated,
    input wire          o_zero_length
);
    import v3u_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_rx)
            && $stable(o_ry) && $stable(o_rz))
        else $error("Output transaction changed while stalled.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("Input not ready although no result is waiting.");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_length |-> o_rx == 32'd0 && o_ry == 32'd0
            && o_rz == (32'd1 << FRAC_BITS) && !o_saturated)
        else $error("Zero-length result is not the unit z vector.");

    a_stall_only_on_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("Input stalled without a blocked output transaction.");

endmodule

bind vector3_op_unit v3u_checker u_v3u_checker (.*);
`default_nettype wire

### test/vector3_op_unit_tb.sv
// Self-checking testbench for the vector operation unit: directed and random transactions.
`default_nettype none
module vector3_op_unit_tb;
    import v3u_pkg::*;

    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = PIPE_LAT + 10;
    localparam int HOLD_CYCLES    = 400;

    localparam longint ARC_TURNS [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_kind = '0;
    t_fix        i_ax = '0, i_ay = '0, i_az = '0, i_bx = '0, i_by = '0, i_bz = '0;
    logic [15:0] i_angle = '0;
    t_fix        i_clip_low = '0, i_clip_high = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_fix        o_rx, o_ry, o_rz;
    logic        o_saturated, o_zero_length;

    t_res expected_vecs[$];
    int   mismatch_count = 0;
    int   src_idle_pct = 0;
    int   snk_stall_pct = 0;
    logic hold_start = 1'b0;
    logic hold_active = 1'b0;
    int   quiet_cycles = 0;

    vector3_op_unit u_top (.*);

    always #10 i_clk = ~i_clk;

    function automatic longint round_half_up(longint d, int s);
        return (d >>> s) + ((d >>> (s - 1)) & 64'sd1);
    endfunction

    function automatic t_fix clip32(longint v, inout logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return 32'h8000_0000;
        end
        return t_fix'(v);
    endfunction

    function automatic void sin_cos_q30(logic [15:0] ang, output longint s, output longint c);
        logic [16:0] folded;
        logic [15:0] a;
        logic        flip;
        longint      x, y, z, dx, dy;
        a = ang;
        folded = {1'b0, a} + 17'd16384;
        flip = folded[15];
        if (flip) a = a ^ 16'h8000;
        x = 652032874;
        y = 0;
        z = longint'($signed(a)) * 65536;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARC_TURNS[i];
            end else begin
                x += dx; y -= dy; z += ARC_TURNS[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endfunction

    function automatic t_fix rotate_term(longint k1, longint u, longint k2, longint v,
                                         inout logic flag);
        return clip32(round_half_up(k1 * u + k2 * v, 30), flag);
    endfunction

    function automatic t_fix cross_term(longint a, longint b, longint c, longint d,
                                        inout logic flag);
        return clip32(round_half_up(a * b - c * d, FRAC_BITS), flag);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > n) bits >>= 2;
        while (bits != 0) begin
            if (n >= res + bits) begin
                n -= res + bits;
                res = (res >> 1) + bits;
            end else begin
                res >>= 1;
            end
            bits >>= 2;
        end
        return res;
    endfunction

    function automatic t_fix unit_term(longint v, int k, logic [63:0] q);
        logic [63:0] m, r;
        m = (v < 0) ? -v : v;
        r = ((m << (FRAC_BITS + k)) + (q >> 1)) / q;
        return (v < 0) ? t_fix'(-r) : t_fix'(r);
    endfunction

    function automatic t_res predict_vec_op(logic [2:0] kind, t_fix ax, t_fix ay, t_fix az,
                                            t_fix bx, t_fix by, t_fix bz, logic [15:0] ang,
                                            t_fix lo, t_fix hi);
        t_res        r;
        longint      s, c;
        logic [63:0] sq, q;
        int          k;
        r = '{rx: ax, ry: ay, rz: az, saturated: 1'b0, zero_length: 1'b0};
        case (kind)
            KIND_CLAMP: begin
                if (r.rx < lo) r.rx = lo;
                if (r.rx > hi) r.rx = hi;
                if (r.ry < lo) r.ry = lo;
                if (r.ry > hi) r.ry = hi;
                if (r.rz < lo) r.rz = lo;
                if (r.rz > hi) r.rz = hi;
            end
            KIND_CROSS: begin
                r.rx = cross_term(ay, bz, az, by, r.saturated);
                r.ry = cross_term(az, bx, ax, bz, r.saturated);
                r.rz = cross_term(ax, by, ay, bx, r.saturated);
            end
            KIND_ROT_X: begin
                sin_cos_q30(ang, s, c);
                r.ry = rotate_term(c, ay, -s, az, r.saturated);
                r.rz = rotate_term(s, ay, c, az, r.saturated);
            end
            KIND_ROT_Y: begin
                sin_cos_q30(ang, s, c);
                r.rx = rotate_term(c, ax, s, az, r.saturated);
                r.rz = rotate_term(c, az, -s, ax, r.saturated);
            end
            KIND_ROT_Z: begin
                sin_cos_q30(ang, s, c);
                r.rx = rotate_term(c, ax, -s, ay, r.saturated);
                r.ry = rotate_term(s, ax, c, ay, r.saturated);
            end
            KIND_NORM: begin
                sq = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
                if (sq == 0) begin
                    r.rx = 0;
                    r.ry = 0;
                    r.rz = 32'sd1 <<< FRAC_BITS;
                    r.zero_length = 1'b1;
                end else begin
                    k = 0;
                    while (sq < (64'd1 << 62)) begin
                        sq <<= 2;
                        k++;
                    end
                    q = int_sqrt(sq);
                    r.rx = unit_term(ax, k, q);
                    r.ry = unit_term(ay, k, q);
                    r.rz = unit_term(az, k, q);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_vec_op(logic [2:0] kind, t_fix ax, t_fix ay, t_fix az, t_fix bx,
                               t_fix by, t_fix bz, logic [15:0] ang, t_fix lo, t_fix hi);
        if ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_ax <= ax; i_ay <= ay; i_az <= az;
        i_bx <= bx; i_by <= by; i_bz <= bz;
        i_angle <= ang;
        i_clip_low <= lo;
        i_clip_high <= hi;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_vecs.push_back(predict_vec_op(kind, ax, ay, az, bx, by, bz, ang, lo, hi));
    endtask

    function automatic t_fix rand_fix();
        case ($urandom_range(3))
            0: return t_fix'($urandom);
            1: return t_fix'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
            2: begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 0;
                    3: return 1;
                    default: return -1;
                endcase
            end
            default: return t_fix'($signed($urandom_range(0, 32'h3FF_FFFF)) - 32'sh200_0000);
        endcase
    endfunction

    task automatic send_random_ops(int count);
        logic [2:0] kind;
        for (int n = 0; n < count; n++) begin
            kind = ($urandom_range(19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
            send_vec_op(kind, rand_fix(), rand_fix(), rand_fix(), rand_fix(), rand_fix(),
                        rand_fix(), 16'($urandom), rand_fix(), rand_fix());
        end
    endtask

    task automatic test_directed();
        t_fix mn, mx;
        mn = 32'h8000_0000;
        mx = 32'h7FFF_FFFF;
        send_vec_op(KIND_CLAMP, mn, mx, 0, 0, 0, 0, 0, -32'sd65536, 32'sd65536);
        send_vec_op(KIND_CLAMP, mn, mx, 5, 0, 0, 0, 0, mn, mx);
        send_vec_op(KIND_CLAMP, -7, 3, 100, 0, 0, 0, 0, 50, -50);
        send_vec_op(KIND_CROSS, mn, mn, mn, mn, mn, mn, 0, 0, 0);
        send_vec_op(KIND_CROSS, mx, mn, mx, mn, mx, mn, 0, 0, 0);
        send_vec_op(KIND_CROSS, 32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0, 0, 0, 0);
        send_vec_op(KIND_CROSS, 1, 1, 1, 32'sh8000, -32'sh8000, 3, 0, 0, 0);
        send_vec_op(KIND_ROT_X, 11, mx, mn, 0, 0, 0, 16'd0, 0, 0);
        send_vec_op(KIND_ROT_X, 11, mx, mx, 0, 0, 0, 16'd8192, 0, 0);
        send_vec_op(KIND_ROT_Y, mx, 9, mn, 0, 0, 0, 16'd16384, 0, 0);
        send_vec_op(KIND_ROT_Y, mn, 9, mn, 0, 0, 0, 16'd32768, 0, 0);
        send_vec_op(KIND_ROT_Z, mx, mx, 4, 0, 0, 0, 16'd49152, 0, 0);
        send_vec_op(KIND_ROT_Z, 32'sh1_0000, 0, 4, 0, 0, 0, 16'hFFFF, 0, 0);
        send_vec_op(KIND_ROT_Z, 32'sh1_0000, 32'sh2_0000, 4, 0, 0, 0, 16'h4000 - 1, 0, 0);
        send_vec_op(KIND_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_vec_op(KIND_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        send_vec_op(KIND_NORM, 0, -1, 0, 0, 0, 0, 0, 0, 0);
        send_vec_op(KIND_NORM, mn, mn, mn, 0, 0, 0, 0, 0, 0);
        send_vec_op(KIND_NORM, mx, mx, mn, 0, 0, 0, 0, 0, 0);
        send_vec_op(KIND_NORM, 32'sh3_0000, 32'sh4_0000, 0, 0, 0, 0, 0, 0, 0);
        send_vec_op(KIND_SPARE_6, mn, mx, 1, mx, mx, mx, 16'hFFFF, mx, mn);
        send_vec_op(KIND_SPARE_7, mx, mn, -1, mn, mn, mn, 16'h8000, mn, mx);
    endtask

    task automatic test_no_idle();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        send_random_ops(150);
    endtask

    task automatic test_sender_idle();
        src_idle_pct = 69;
        snk_stall_pct = 0;
        send_random_ops(130);
    endtask

    task automatic test_receiver_stall();
        src_idle_pct = 0;
        snk_stall_pct = 69;
        send_random_ops(130);
    endtask

    task automatic test_both_idle();
        src_idle_pct = 28;
        snk_stall_pct = 28;
        send_random_ops(130);
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_start = 1'b1;
        send_random_ops(130);
    endtask

    // The receiver holds ready low for a long stretch once it is requested.
    initial begin
        wait (hold_start);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // The receiver drives ready and checks every output transaction.
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (hold_active) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= snk_stall_pct);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_vecs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Unexpected transaction: rx=%0d ry=%0d rz=%0d", o_rx, o_ry, o_rz);
                    end
                end else begin
                    want = expected_vecs.pop_front();
                    if (o_rx !== want.rx || o_ry !== want.ry || o_rz !== want.rz
                            || o_saturated !== want.saturated
                            || o_zero_length !== want.zero_length) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("Mismatch: expected %0d %0d %0d sat=%0b zl=%0b",
                                     want.rx, want.ry, want.rz, want.saturated,
                                     want.zero_length);
                            $display("          actual   %0d %0d %0d sat=%0b zl=%0b",
                                     o_rx, o_ry, o_rz, o_saturated, o_zero_length);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        i_in_valid <= 1'b0;
        snk_stall_pct = 0;
        while (expected_vecs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
